/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* sv/nprmf_pkg.sv */
`default_nettype none

package nprmf_pkg;

	// defaults for the frame geometry
	localparam int DEF_ROW_BYTES = 160;
	localparam int DEF_ADDR_BITS = 16;

	// fixed field widths
	localparam int COORD_W = 9;
	localparam int SIDE_W  = 8;
	localparam int XCNT_W  = COORD_W + 1;
	localparam int BUF_AW  = 2 * SIDE_W;

	// operation codes
	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_MOVE  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

endpackage

`default_nettype wire

/* sv/nibble_pixel_rect_move_fill_top.sv */
// Byte write: write state, then result beat; byte read: read, read wait, result.
// Move: row-base multiplies, then passes (W*H = 0 goes straight to the result)
// on the single memory port: one read per pixel to capture the source, then a
// read and a write per pixel for the fill and for the target, then the result.
// busy is high after the accepted start until the result beat; the next start is taken then.
// arst_n clears the control state; frame memory contents are undefined.
`default_nettype none

`include "assert_macros.svh"

module nibble_pixel_rect_move_fill_top
	import nprmf_pkg::*;
#(
	parameter int ROW_BYTES = DEF_ROW_BYTES,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          mode,
	input  wire logic [15:0]         address,
	input  wire logic [7:0]          write_data,
	input  wire logic [COORD_W-1:0]  source_x,
	input  wire logic [COORD_W-1:0]  source_y,
	input  wire logic [COORD_W-1:0]  target_x,
	input  wire logic [COORD_W-1:0]  target_y,
	input  wire logic [SIDE_W-1:0]   rect_width,
	input  wire logic [SIDE_W-1:0]   rect_height,
	input  wire logic [3:0]          fill_colour,
	output logic                     valid,
	output logic [7:0]               read_data,
	output logic                     op_done
);

	localparam int ROW_W   = $clog2(ROW_BYTES + 1);
	localparam int PROD_W  = COORD_W + ROW_W;
	localparam int PW      = (PROD_W > ADDR_BITS) ? PROD_W : ADDR_BITS;
	localparam int MEM_DEPTH = 1 << ADDR_BITS;
	localparam int BUF_DEPTH = 1 << BUF_AW;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WRITE,
		S_READ,
		S_RD_WAIT,
		S_MUL_SRC,
		S_MUL_DST,
		S_CAP,
		S_FILL_RD,
		S_FILL_WR,
		S_DST_RD,
		S_DST_WR,
		S_FIN
	} state_t;

	state_t                 state_q;
	mode_t                  mode_q;
	logic [ADDR_BITS-1:0]   addr_q;
	logic [7:0]             wdata_q;
	logic [COORD_W-1:0]     sx_q, sy_q, dx_q, dy_q;
	logic [SIDE_W-1:0]      w_q, h_q;
	logic [3:0]             fill_q;

	// walk state
	logic [ADDR_BITS-1:0]   src_base_q, dst_base_q, row_base_q;
	logic [XCNT_W-1:0]      x_q, x0_q;
	logic [SIDE_W-1:0]      i_q, j_q;

	// capture pipeline
	logic                   cap_v_s1;
	logic                   cap_odd_s1;
	logic [BUF_AW-1:0]      cap_idx_s1;

	// result registers
	logic                   valid_q;
	logic [7:0]             read_data_q;
	logic                   op_done_q;

	// memories
	logic [7:0]             frame_mem [MEM_DEPTH];
	logic [3:0]             pix_buf [BUF_DEPTH];
	logic [7:0]             rdata_q;
	logic [3:0]             pb_rdata_q;

	logic                   accept;
	logic                   col_end, last_px;
	logic [ADDR_BITS-1:0]   pix_addr;
	logic [COORD_W-1:0]     mul_y;
	logic [PW-1:0]          prod;
	logic [3:0]             nib;
	logic [7:0]             merged;
	logic                   mem_we, mem_re;
	logic [ADDR_BITS-1:0]   mem_addr;
	logic [7:0]             mem_wdata;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign valid     = valid_q;
	assign read_data = read_data_q;
	assign op_done   = op_done_q;

	// position tests and byte address of the current pixel
	assign col_end  = (i_q == w_q - SIDE_W'(1));
	assign last_px  = col_end && (j_q == h_q - SIDE_W'(1));
	assign pix_addr = row_base_q + ADDR_BITS'(x_q[XCNT_W-1:1]);

	// row base: y * ROW_BYTES, registered before use
	assign mul_y = (state_q == S_MUL_SRC) ? sy_q : dy_q;
	assign prod  = PW'(mul_y) * PW'(ROW_BYTES);

	// nibble merge for read-modify-write
	assign nib    = (state_q == S_DST_WR) ? pb_rdata_q : fill_q;
	assign merged = x_q[0] ? {rdata_q[7:4], nib} : {nib, rdata_q[3:0]};

	// frame memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = pix_addr;
		mem_wdata = merged;
		unique case (state_q)
			S_WRITE: begin
				mem_we    = 1'b1;
				mem_addr  = addr_q;
				mem_wdata = wdata_q;
			end
			S_READ: begin
				mem_re   = 1'b1;
				mem_addr = addr_q;
			end
			S_CAP, S_FILL_RD, S_DST_RD: mem_re = 1'b1;
			S_FILL_WR, S_DST_WR: mem_we = 1'b1;
			default: ;
		endcase
	end

	// frame memory, one port
	always_ff @(posedge clk) begin
		if (mem_we)
			frame_mem[mem_addr] <= mem_wdata;
		if (mem_re)
			rdata_q <= frame_mem[mem_addr];
	end

	// source pixel buffer: written by capture, read during target pass
	always_ff @(posedge clk) begin
		if (cap_v_s1)
			pix_buf[cap_idx_s1] <= cap_odd_s1 ? rdata_q[3:0] : rdata_q[7:4];
		if (state_q == S_DST_RD)
			pb_rdata_q <= pix_buf[{j_q, i_q}];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_NONE;
			addr_q      <= '0;
			wdata_q     <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			w_q         <= '0;
			h_q         <= '0;
			fill_q      <= '0;
			src_base_q  <= '0;
			dst_base_q  <= '0;
			row_base_q  <= '0;
			x_q         <= '0;
			x0_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			cap_v_s1    <= 1'b0;
			cap_odd_s1  <= 1'b0;
			cap_idx_s1  <= '0;
			valid_q     <= 1'b0;
			read_data_q <= '0;
			op_done_q   <= 1'b0;
		end else begin
			valid_q  <= 1'b0;
			cap_v_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q  <= mode_t'(mode);
						addr_q  <= ADDR_BITS'(address);
						wdata_q <= write_data;
						sx_q    <= source_x;
						sy_q    <= source_y;
						dx_q    <= target_x;
						dy_q    <= target_y;
						w_q     <= rect_width;
						h_q     <= rect_height;
						fill_q  <= fill_colour;
						unique case (mode_t'(mode))
							MODE_WRITE: state_q <= S_WRITE;
							MODE_READ:  state_q <= S_READ;
							MODE_MOVE: begin
								if (rect_width != '0 && rect_height != '0)
									state_q <= S_MUL_SRC;
								else
									state_q <= S_FIN;
							end
							MODE_NONE:  state_q <= S_FIN;
						endcase
					end
				end
				S_WRITE: begin
					valid_q     <= 1'b1;
					op_done_q   <= 1'b1;
					read_data_q <= '0;
					state_q     <= S_IDLE;
				end
				S_READ: state_q <= S_RD_WAIT;
				S_RD_WAIT: begin
					valid_q     <= 1'b1;
					op_done_q   <= 1'b1;
					read_data_q <= rdata_q;
					state_q     <= S_IDLE;
				end
				S_MUL_SRC: begin
					src_base_q <= ADDR_BITS'(prod);
					state_q    <= S_MUL_DST;
				end
				S_MUL_DST: begin
					dst_base_q <= ADDR_BITS'(prod);
					row_base_q <= src_base_q;
					x_q        <= XCNT_W'(sx_q);
					x0_q       <= XCNT_W'(sx_q);
					i_q        <= '0;
					j_q        <= '0;
					state_q    <= S_CAP;
				end
				S_CAP: begin
					cap_v_s1   <= 1'b1;
					cap_odd_s1 <= x_q[0];
					cap_idx_s1 <= {j_q, i_q};
					if (last_px) begin
						// restart the walk over the source for the fill pass
						row_base_q <= src_base_q;
						x_q        <= XCNT_W'(sx_q);
						x0_q       <= XCNT_W'(sx_q);
						i_q        <= '0;
						j_q        <= '0;
						state_q    <= S_FILL_RD;
					end else if (col_end) begin
						i_q        <= '0;
						x_q        <= x0_q;
						j_q        <= j_q + SIDE_W'(1);
						row_base_q <= row_base_q + ADDR_BITS'(ROW_BYTES);
					end else begin
						i_q <= i_q + SIDE_W'(1);
						x_q <= x_q + XCNT_W'(1);
					end
				end
				S_FILL_RD: state_q <= S_FILL_WR;
				S_FILL_WR: begin
					if (last_px) begin
						// walk the target next
						row_base_q <= dst_base_q;
						x_q        <= XCNT_W'(dx_q);
						x0_q       <= XCNT_W'(dx_q);
						i_q        <= '0;
						j_q        <= '0;
						state_q    <= S_DST_RD;
					end else begin
						if (col_end) begin
							i_q        <= '0;
							x_q        <= x0_q;
							j_q        <= j_q + SIDE_W'(1);
							row_base_q <= row_base_q + ADDR_BITS'(ROW_BYTES);
						end else begin
							i_q <= i_q + SIDE_W'(1);
							x_q <= x_q + XCNT_W'(1);
						end
						state_q <= S_FILL_RD;
					end
				end
				S_DST_RD: state_q <= S_DST_WR;
				S_DST_WR: begin
					if (last_px) begin
						valid_q     <= 1'b1;
						op_done_q   <= 1'b1;
						read_data_q <= '0;
						state_q     <= S_IDLE;
					end else begin
						if (col_end) begin
							i_q        <= '0;
							x_q        <= x0_q;
							j_q        <= j_q + SIDE_W'(1);
							row_base_q <= row_base_q + ADDR_BITS'(ROW_BYTES);
						end else begin
							i_q <= i_q + SIDE_W'(1);
							x_q <= x_q + XCNT_W'(1);
						end
						state_q <= S_DST_RD;
					end
				end
				S_FIN: begin
					// empty move completes; unused code reports not done
					valid_q     <= 1'b1;
					op_done_q   <= (mode_q == MODE_MOVE);
					read_data_q <= '0;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	`ASSERT_AT(a_accept_busy, clk, arst_n, accept |=> busy, "accepted beat did not raise busy")
	`ASSERT_AT(a_one_beat, clk, arst_n, valid |=> !valid, "more than one result beat per item")
	`ASSERT_NEVER(a_valid_busy, clk, arst_n, valid && busy, "result beat while still busy")
	`ASSERT_NEVER(a_idle_write, clk, arst_n, mem_we && !busy, "frame write while idle")
	`ASSERT_AT(a_zero_rd, clk, arst_n, (valid && !op_done) |-> (read_data == 8'd0),
		"nonzero read data on an unused code")

endmodule

`default_nettype wire
